/* src/bmal_pkg.sv */
// ----------------------------------------------------------------------------
// Block map allocator package
// Shared widths, opcode and status codes, default sizes and the shift
// control beat that the controller hands to every cell of the map chain.
// ----------------------------------------------------------------------------
package bmal_pkg;

  localparam int ENTRY_W  = 8;
  localparam int OP_W     = 1;
  localparam int BYTES_W  = 17;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int PCT_W    = 7;

  localparam int MAX_RUN  = 255;

  localparam int DEF_BLOCK_BYTES = 512;
  localparam int DEF_MAP_ENTRIES = 128;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NORUN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic               fwd;
    logic               rev;
    logic               mark;
    logic [ENTRY_W-1:0] val;
  } bmal_shift_t;

endpackage

/* src/bmal_cell.sv */
// ----------------------------------------------------------------------------
// Block map cell
// One map entry of the rotating chain. Takes its neighbor's entry on a
// forward or reverse shift, or the run length when a mark covers its slot.
// ----------------------------------------------------------------------------
module bmal_cell #(
  parameter int MAP_ENTRIES = bmal_pkg::DEF_MAP_ENTRIES,
  parameter int POS         = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bmal_pkg::bmal_shift_t              shift,
  input  logic [$clog2(MAP_ENTRIES)-1:0]     thresh,
  input  logic [bmal_pkg::ENTRY_W-1:0]       from_hi,
  input  logic [bmal_pkg::ENTRY_W-1:0]       from_lo,
  output logic [bmal_pkg::ENTRY_W-1:0]       data
);
  import bmal_pkg::*;

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  logic [ENTRY_W-1:0] data_r;
  logic [ENTRY_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift.fwd) begin
      data_nxt = (shift.mark && (IDX_W'(POS) >= thresh)) ? shift.val : from_hi;
    end else if (shift.rev) begin
      data_nxt = from_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

/* src/bmal_ctrl.sv */
// ----------------------------------------------------------------------------
// Block map controller
// Sequences one full rotation of the cell chain per accepted request: scans
// for the first long enough free run top down or clears a freed allocation
// bottom up, counts occupied entries and converts the count to percent.
// ----------------------------------------------------------------------------
module bmal_ctrl #(
  parameter int BLOCK_BYTES = bmal_pkg::DEF_BLOCK_BYTES,
  parameter int MAP_ENTRIES = bmal_pkg::DEF_MAP_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bmal_pkg::OP_W-1:0]           in_opcode,
  input  logic [bmal_pkg::BYTES_W-1:0]        in_request_bytes,
  input  logic [bmal_pkg::OFFSET_W-1:0]       in_free_offset,
  input  logic [bmal_pkg::ENTRY_W-1:0]        head,
  input  logic [bmal_pkg::ENTRY_W-1:0]        tail,
  output bmal_pkg::bmal_shift_t               shift,
  output logic [$clog2(MAP_ENTRIES)-1:0]      thresh,
  output logic [bmal_pkg::ENTRY_W-1:0]        rev_in,
  output logic                                out_strobe,
  output logic [bmal_pkg::STATUS_W-1:0]       out_status,
  output logic [bmal_pkg::OFFSET_W-1:0]       out_granted_offset,
  output logic [bmal_pkg::PCT_W-1:0]          out_usage_percent
);
  import bmal_pkg::*;

  localparam int IDX_W      = $clog2(MAP_ENTRIES);
  localparam int CNT_W      = $clog2(MAP_ENTRIES + 1);
  localparam int LIMIT      = (MAP_ENTRIES < MAX_RUN) ? MAP_ENTRIES : MAX_RUN;
  localparam int POOL_BYTES = BLOCK_BYTES * MAP_ENTRIES;
  localparam int ACC_W      = $clog2(POOL_BYTES + BLOCK_BYTES + (1 << BYTES_W));

  localparam int          PCT_SHIFT = BYTES_W + $clog2(MAP_ENTRIES);
  localparam logic [63:0] PCT_RECIP = ((64'd1 << PCT_SHIFT) + 64'(MAP_ENTRIES) - 64'd1)
                                      / 64'(MAP_ENTRIES);
  localparam logic [63:0] PCT_MUL   = PCT_RECIP * 64'd100;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;
  localparam logic [1:0] S_CALC  = 2'd3;

  logic [1:0]          state_r;
  logic [IDX_W-1:0]    step_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                found_r;
  logic [ENTRY_W-1:0]  run_r;
  logic [ENTRY_W-1:0]  need_r;
  logic [ENTRY_W-1:0]  rem_r;
  logic [ACC_W-1:0]    bsum_r;
  logic [CNT_W-1:0]    acc_r;
  logic [CNT_W-1:0]    used_r;
  logic [PCT_W-1:0]    pct_r;
  logic [STATUS_W-1:0] status_r;
  logic [OFFSET_W-1:0] grant_r;

  logic                out_strobe_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFFSET_W-1:0] out_grant_r;
  logic [PCT_W-1:0]    out_pct_r;

  logic [ACC_W-1:0]    sum_b;
  logic                head_free;
  logic                a_hit;
  logic                f_hit;
  logic                f_clear;
  logic [ENTRY_W-1:0]  a_need;
  logic                last;
  logic                count_bit;
  logic [CNT_W-1:0]    acc_inc;
  logic [ENTRY_W-1:0]  used_add;
  logic [IDX_W-1:0]    blk;
  logic [OFFSET_W-1:0] grant_calc;
  logic [PCT_W-1:0]    pct_calc;

  always_comb begin
    sum_b      = bsum_r + ACC_W'(BLOCK_BYTES);
    head_free  = (head == '0);
    a_need     = run_r + 8'd1;
    a_hit      = (state_r == S_ALLOC) && !found_r && head_free
                 && (sum_b >= ACC_W'(bytes_r));
    f_hit      = (state_r == S_FREE) && !found_r && (ACC_W'(offset_r) < sum_b);
    f_clear    = f_hit ? (tail != '0) : (found_r && (rem_r != '0));
    rev_in     = f_clear ? '0 : tail;
    last       = (step_r == IDX_W'(MAP_ENTRIES - 1));
    count_bit  = (state_r == S_ALLOC) ? !head_free : (rev_in != '0);
    acc_inc    = acc_r + CNT_W'(count_bit);
    used_add   = found_r ? need_r : (a_hit ? a_need : '0);
    blk        = IDX_W'(MAP_ENTRIES - 1) - step_r;
    grant_calc = OFFSET_W'(32'(blk) * 32'(BLOCK_BYTES));
    pct_calc   = PCT_W'((64'(used_r) * PCT_MUL) >> PCT_SHIFT);
  end

  always_comb begin
    shift.fwd  = (state_r == S_ALLOC);
    shift.rev  = (state_r == S_FREE);
    shift.mark = a_hit;
    shift.val  = a_need;
    thresh     = IDX_W'(MAP_ENTRIES - int'(a_need));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      pct_r        <= '0;
      used_r       <= '0;
      found_r      <= 1'b0;
      step_r       <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            bytes_r  <= in_request_bytes;
            offset_r <= in_free_offset;
            found_r  <= 1'b0;
            run_r    <= '0;
            bsum_r   <= '0;
            rem_r    <= '0;
            acc_r    <= '0;
            step_r   <= '0;
            grant_r  <= '0;
            if (in_opcode == OP_ALLOC) begin
              status_r <= ST_NORUN;
              if (in_request_bytes == '0) begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_ZERO;
                out_grant_r  <= '0;
                out_pct_r    <= pct_r;
              end else if (32'(in_request_bytes) > 32'(LIMIT * BLOCK_BYTES)) begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_NORUN;
                out_grant_r  <= '0;
                out_pct_r    <= pct_r;
              end else begin
                state_r <= S_ALLOC;
              end
            end else begin
              status_r <= ST_OK;
              if (32'(in_free_offset) >= 32'(POOL_BYTES)) begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_RANGE;
                out_grant_r  <= '0;
                out_pct_r    <= pct_r;
              end else begin
                state_r <= S_FREE;
              end
            end
          end
        end
        S_ALLOC: begin
          step_r <= step_r + 1'b1;
          acc_r  <= acc_inc;
          if (!found_r) begin
            if (head_free) begin
              run_r  <= a_need;
              bsum_r <= sum_b;
            end else begin
              run_r  <= '0;
              bsum_r <= '0;
            end
          end
          if (a_hit) begin
            found_r  <= 1'b1;
            need_r   <= a_need;
            status_r <= ST_OK;
            grant_r  <= grant_calc;
          end
          if (last) begin
            state_r <= S_CALC;
            used_r  <= acc_inc + CNT_W'(used_add);
          end
        end
        S_FREE: begin
          step_r <= step_r + 1'b1;
          acc_r  <= acc_inc;
          bsum_r <= sum_b;
          if (f_hit) begin
            found_r <= 1'b1;
            rem_r   <= (tail == '0) ? '0 : tail - 1'b1;
          end else if (f_clear) begin
            rem_r <= rem_r - 1'b1;
          end
          if (last) begin
            state_r <= S_CALC;
            used_r  <= acc_inc;
          end
        end
        S_CALC: begin
          pct_r        <= pct_calc;
          out_strobe_r <= 1'b1;
          out_status_r <= status_r;
          out_grant_r  <= grant_r;
          out_pct_r    <= pct_calc;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_grant_r;
  assign out_usage_percent  = out_pct_r;

endmodule

/* src/block_map_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Block map allocator unit
// Result: allocate and in-range free give their beat after a full turn of the
//   cell chain and S_CALC; zero size, oversize and out-of-range requests the
//   next cycle. Throughput: busy holds a new rotating request off for a full
//   turn of the chain at one entry a cycle; rejected requests one a cycle.
// Reset: synchronous, clears every map cell and the usage figure.
// ----------------------------------------------------------------------------
module block_map_allocator_unit #(
  parameter int BLOCK_BYTES = bmal_pkg::DEF_BLOCK_BYTES,
  parameter int MAP_ENTRIES = bmal_pkg::DEF_MAP_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bmal_pkg::OP_W-1:0]       in_opcode,
  input  logic [bmal_pkg::BYTES_W-1:0]    in_request_bytes,
  input  logic [bmal_pkg::OFFSET_W-1:0]   in_free_offset,
  output logic                            out_strobe,
  output logic [bmal_pkg::STATUS_W-1:0]   out_status,
  output logic [bmal_pkg::OFFSET_W-1:0]   out_granted_offset,
  output logic [bmal_pkg::PCT_W-1:0]      out_usage_percent
);
  import bmal_pkg::*;

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  logic [ENTRY_W-1:0] data [MAP_ENTRIES];
  bmal_shift_t        shift;
  logic [IDX_W-1:0]   thresh;
  logic [ENTRY_W-1:0] rev_in;

  bmal_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_request_bytes   (in_request_bytes),
    .in_free_offset     (in_free_offset),
    .head               (data[0]),
    .tail               (data[MAP_ENTRIES-1]),
    .shift              (shift),
    .thresh             (thresh),
    .rev_in             (rev_in),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_usage_percent  (out_usage_percent)
  );

  for (genvar i = 0; i < MAP_ENTRIES; i++) begin : g_cell
    logic [ENTRY_W-1:0] hi;
    logic [ENTRY_W-1:0] lo;

    if (i == MAP_ENTRIES - 1) begin : g_hi_wrap
      assign hi = data[0];
    end else begin : g_hi
      assign hi = data[i+1];
    end

    if (i == 0) begin : g_lo_wrap
      assign lo = rev_in;
    end else begin : g_lo
      assign lo = data[i-1];
    end

    bmal_cell #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .POS         (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .thresh  (thresh),
      .from_hi (hi),
      .from_lo (lo),
      .data    (data[i])
    );
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while a scan is running");

  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_ALLOC) && (in_request_bytes == '0))
    |=> (out_strobe && (out_status == ST_ZERO)))
    else $error("zero size request not rejected on the next cycle");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> (out_granted_offset == '0))
    else $error("failed request carries a nonzero offset");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_usage_percent <= 7'd100))
    else $error("usage above one hundred percent");

endmodule
